// ===== design/gmrc_pkg.sv =====
`default_nettype none
package gmrc_pkg;

    typedef enum logic [3:0] {
        CMD_WRITE     = 4'd0,
        CMD_READ      = 4'd1,
        CMD_SWAP_ROW  = 4'd2,
        CMD_CLR_ROW   = 4'd3,
        CMD_XOR_ROW   = 4'd4,
        CMD_XOR_FROM  = 4'd5,
        CMD_COPY_ROW  = 4'd6,
        CMD_ZERO_TEST = 4'd7,
        CMD_SWAP_COL  = 4'd8,
        CMD_CLR_COL   = 4'd9,
        CMD_COPY_COL  = 4'd10
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_WAIT,
        ST_WR_A,
        ST_WR_B,
        ST_DONE
    } state_t;

    localparam logic [0:0] REG_ROWS = 1'b0;
    localparam logic [0:0] REG_COLS = 1'b1;

endpackage
`default_nettype wire

// ===== design/gmrc_mem.sv =====
`default_nettype none
// Word store with one write port and one registered read port.
module gmrc_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read in the same clocked block.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/gf2_matrix_row_col_engine_unit.sv =====
`default_nettype none
// Write and read give their result after the steps read A, read B, wait, write A and write B; errors,
//   unused codes and commands with nothing to do give it straight after the first read A step.
// Row commands repeat these steps for each word visited; column commands repeat them
//   for each row visited.
// Throughput: one command at a time; in_stall is high until the result transfers.
// Reset: control state and config registers clear (rows and cols to 256);
//   the word store is not cleared.
module gf2_matrix_row_col_engine_unit #(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_COLS  = 256,
    parameter int WORD_BITS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  command,
    input  wire logic [7:0]  row_a,
    input  wire logic [7:0]  row_b,
    input  wire logic [7:0]  col_a,
    input  wire logic [7:0]  col_b,
    input  wire logic [8:0]  start_req,
    input  wire logic        scale,
    input  wire logic [1:0]  word_select,
    input  wire logic [63:0] write_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      read_data,
    output logic             row_is_zero,
    output logic             error
);
    localparam int WPR   = (MAX_COLS + WORD_BITS - 1) / WORD_BITS;
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int DEPTH = MAX_ROWS * WPR;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(WORD_BITS);

    logic [8:0] rows_cfg_reg, cols_cfg_reg;
    gmrc_pkg::state_t state_reg, state_next;
    gmrc_pkg::cmd_t   cmd_reg;
    logic [7:0]  ra_reg, rb_reg, ca_reg, cb_reg;
    logic [8:0]  start_reg;
    logic        scale_reg;
    logic [1:0]  ws_reg;
    logic [63:0] wd_reg;
    logic [8:0]  idx_reg, idx_next;
    logic [63:0] va_reg, vb_reg;
    logic [63:0] rd_reg;
    logic        zero_reg, err_reg;

    // Effective row and column counts, clipped to the store size.
    logic [8:0] rows_eff, cols_eff;
    logic [8:0] nw;
    always_comb
    begin
        rows_eff = (32'(rows_cfg_reg) > MAX_ROWS) ? 9'(MAX_ROWS) : rows_cfg_reg;
        cols_eff = (32'(cols_cfg_reg) > MAX_COLS) ? 9'(MAX_COLS) : cols_cfg_reg;
        nw = 9'((32'(cols_eff) + WORD_BITS - 1) / WORD_BITS);
    end

    // Memory port signals.
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [63:0]   mem_wdata, mem_rdata;
    logic [WORD_BITS-1:0] mem_rq;

    gmrc_mem #(.DEPTH(DEPTH), .WIDTH(WORD_BITS)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata[WORD_BITS-1:0]),
        .raddr (mem_raddr),
        .rdata (mem_rq)
    );
    assign mem_rdata = 64'(mem_rq);

    function automatic logic [AW-1:0] addr_of(input logic [8:0] r, input logic [8:0] w);
        addr_of = AW'(32'(r[RW-1:0]) * WPR + 32'(w));
    endfunction

    // Decode of the held command.
    logic is_col, is_row, bad, is_noop_row;
    logic [8:0] wa_col, wb_col;
    logic [63:0] ma, mb, start_mask, last_mask;
    logic [8:0] loop_end, loop_start;
    logic [8:0] idx_cur;
    always_comb
    begin
        is_col = (cmd_reg == gmrc_pkg::CMD_SWAP_COL) || (cmd_reg == gmrc_pkg::CMD_CLR_COL)
              || (cmd_reg == gmrc_pkg::CMD_COPY_COL);
        is_row = (cmd_reg == gmrc_pkg::CMD_SWAP_ROW) || (cmd_reg == gmrc_pkg::CMD_CLR_ROW)
              || (cmd_reg == gmrc_pkg::CMD_XOR_ROW) || (cmd_reg == gmrc_pkg::CMD_XOR_FROM)
              || (cmd_reg == gmrc_pkg::CMD_COPY_ROW) || (cmd_reg == gmrc_pkg::CMD_ZERO_TEST);
        bad = 1'b0;
        case (cmd_reg)
            gmrc_pkg::CMD_WRITE, gmrc_pkg::CMD_READ:
                bad = ({1'b0, ra_reg} >= rows_eff) || ({7'd0, ws_reg} >= nw);
            gmrc_pkg::CMD_CLR_ROW, gmrc_pkg::CMD_ZERO_TEST:
                bad = {1'b0, ra_reg} >= rows_eff;
            gmrc_pkg::CMD_SWAP_ROW, gmrc_pkg::CMD_XOR_ROW, gmrc_pkg::CMD_COPY_ROW:
                bad = ({1'b0, ra_reg} >= rows_eff) || ({1'b0, rb_reg} >= rows_eff);
            gmrc_pkg::CMD_XOR_FROM:
                bad = ({1'b0, ra_reg} >= rows_eff) || ({1'b0, rb_reg} >= rows_eff)
                   || (start_reg > cols_eff);
            gmrc_pkg::CMD_SWAP_COL, gmrc_pkg::CMD_COPY_COL:
                bad = ({1'b0, ca_reg} >= cols_eff) || ({1'b0, cb_reg} >= cols_eff);
            gmrc_pkg::CMD_CLR_COL:
                bad = ({1'b0, ca_reg} >= cols_eff) || (start_reg > rows_eff);
            default: bad = 1'b0;
        endcase
        is_noop_row = ((cmd_reg == gmrc_pkg::CMD_CLR_ROW) && scale_reg)
                   || ((cmd_reg == gmrc_pkg::CMD_XOR_ROW) && !scale_reg)
                   || ((cmd_reg == gmrc_pkg::CMD_XOR_FROM) && (!scale_reg
                        || start_reg >= cols_eff))
                   || ((cmd_reg == gmrc_pkg::CMD_COPY_ROW) && (ra_reg == rb_reg))
                   || ((cmd_reg == gmrc_pkg::CMD_CLR_COL) && scale_reg);
        wa_col = 9'(ca_reg >> BW);
        wb_col = 9'(cb_reg >> BW);
        ma = 64'd1 << ca_reg[BW-1:0];
        mb = 64'd1 << cb_reg[BW-1:0];
        start_mask = ~((64'd1 << start_reg[BW-1:0]) - 64'd1);
        if (is_col)
        begin
            loop_end = rows_eff;
            loop_start = (cmd_reg == gmrc_pkg::CMD_CLR_COL) ? start_reg : 9'd0;
        end
        else
        begin
            loop_end = nw;
            loop_start = (cmd_reg == gmrc_pkg::CMD_XOR_FROM) ? 9'(start_reg >> BW) : 9'd0;
        end
        // On the first visit the loop index is still zero; the walk begins at its start.
        idx_cur = (idx_reg == 9'd0) ? loop_start : idx_reg;
        last_mask = ~64'd0;
        if (32'(cols_eff) - 32'(idx_cur) * WORD_BITS < WORD_BITS)
        begin
            last_mask = (64'd1 << BW'(cols_eff)) - 64'd1;
        end
    end

    // Row and word addresses for the A and B accesses of the current step.
    logic [AW-1:0] addr_a, addr_b;
    always_comb
    begin
        if (is_col)
        begin
            addr_a = addr_of(idx_cur, wa_col);
            addr_b = addr_of(idx_cur, wb_col);
        end
        else if (cmd_reg == gmrc_pkg::CMD_WRITE || cmd_reg == gmrc_pkg::CMD_READ)
        begin
            addr_a = addr_of({1'b0, ra_reg}, {7'd0, ws_reg});
            addr_b = addr_a;
        end
        else
        begin
            addr_a = addr_of({1'b0, ra_reg}, idx_cur);
            addr_b = addr_of({1'b0, rb_reg}, idx_cur);
        end
    end

    // Shared update unit: new values for the A and B words.
    logic [63:0] new_a, new_b;
    logic        wr_a, wr_b;
    always_comb
    begin
        new_a = va_reg;
        new_b = vb_reg;
        wr_a = 1'b0;
        wr_b = 1'b0;
        case (cmd_reg)
            gmrc_pkg::CMD_SWAP_ROW:
            begin
                new_a = vb_reg; new_b = va_reg; wr_a = 1'b1; wr_b = 1'b1;
            end
            gmrc_pkg::CMD_CLR_ROW:
            begin
                new_a = 64'd0; wr_a = 1'b1;
            end
            gmrc_pkg::CMD_XOR_ROW:
            begin
                new_b = vb_reg ^ va_reg; wr_b = 1'b1;
            end
            gmrc_pkg::CMD_XOR_FROM:
            begin
                new_b = vb_reg ^ ((idx_cur == 9'(start_reg >> BW)) ? (va_reg & start_mask)
                                                                     : va_reg);
                wr_b = 1'b1;
            end
            gmrc_pkg::CMD_COPY_ROW:
            begin
                new_b = va_reg; wr_b = 1'b1;
            end
            gmrc_pkg::CMD_SWAP_COL:
            begin
                new_a = ((vb_reg & mb) != 64'd0) ? (va_reg | ma) : (va_reg & ~ma);
                wr_a = 1'b1;
                // For the same-word case the B write uses vb_after instead of this value.
                new_b = ((va_reg & ma) != 64'd0) ? (vb_reg | mb) : (vb_reg & ~mb);
                wr_b = 1'b1;
            end
            gmrc_pkg::CMD_COPY_COL:
            begin
                new_b = ((va_reg & ma) != 64'd0) ? (vb_reg | mb) : (vb_reg & ~mb);
                wr_b = 1'b1;
            end
            gmrc_pkg::CMD_CLR_COL:
            begin
                new_a = va_reg & ~ma; wr_a = 1'b1;
            end
            default:
            begin
                new_a = va_reg;
            end
        endcase
    end

    // Swap of columns: bit of A taken from the B word, bit of B from the A word.
    // va holds word A, vb word B; for the same word the B write is based on the
    // value after the A write.
    logic [63:0] vb_after;
    assign vb_after = (addr_a == addr_b) ? new_a : vb_reg;

    // Next-state logic.
    logic single, loop_done;
    always_comb
    begin
        single = (cmd_reg == gmrc_pkg::CMD_WRITE) || (cmd_reg == gmrc_pkg::CMD_READ);
        loop_done = idx_cur >= loop_end;
        state_next = state_reg;
        idx_next = idx_reg;
        case (state_reg)
            gmrc_pkg::ST_IDLE:
            begin
                idx_next = 9'd0;
                if (in_valid)
                begin
                    state_next = gmrc_pkg::ST_RD_A;
                end
            end
            gmrc_pkg::ST_RD_A:
            begin
                // First visit: position the loop.
                if (idx_reg == 9'd0)
                begin
                    idx_next = (bad || is_noop_row) ? loop_end : loop_start;
                end
                if (bad || (!is_row && !is_col && !single)
                    || ((is_row || is_col) && (is_noop_row || loop_done)))
                begin
                    state_next = gmrc_pkg::ST_DONE;
                end
                else
                begin
                    state_next = gmrc_pkg::ST_RD_B;
                end
            end
            gmrc_pkg::ST_RD_B:  state_next = gmrc_pkg::ST_WAIT;
            gmrc_pkg::ST_WAIT:  state_next = gmrc_pkg::ST_WR_A;
            gmrc_pkg::ST_WR_A:  state_next = gmrc_pkg::ST_WR_B;
            gmrc_pkg::ST_WR_B:
            begin
                idx_next = idx_cur + 9'd1;
                state_next = single ? gmrc_pkg::ST_DONE : gmrc_pkg::ST_RD_A;
            end
            gmrc_pkg::ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = gmrc_pkg::ST_IDLE;
                end
            end
            default: state_next = gmrc_pkg::ST_IDLE;
        endcase
    end

    // Output and memory control logic.
    always_comb
    begin
        in_stall = (state_reg != gmrc_pkg::ST_IDLE);
        out_valid = (state_reg == gmrc_pkg::ST_DONE);
        mem_raddr = addr_a;
        mem_we = 1'b0;
        mem_waddr = addr_a;
        mem_wdata = new_a;
        case (state_reg)
            gmrc_pkg::ST_RD_A: mem_raddr = addr_a;
            gmrc_pkg::ST_RD_B: mem_raddr = addr_b;
            gmrc_pkg::ST_WR_A:
            begin
                mem_waddr = addr_a;
                mem_wdata = (cmd_reg == gmrc_pkg::CMD_WRITE) ? wd_reg : new_a;
                mem_we = wr_a || (cmd_reg == gmrc_pkg::CMD_WRITE);
            end
            gmrc_pkg::ST_WR_B:
            begin
                mem_waddr = addr_b;
                mem_we = wr_b;
                if (cmd_reg == gmrc_pkg::CMD_SWAP_COL)
                begin
                    mem_wdata = ((va_reg & ma) != 64'd0) ? (vb_after | mb) : (vb_after & ~mb);
                end
                else
                begin
                    mem_wdata = new_b;
                end
            end
            default: mem_we = 1'b0;
        endcase
    end
    assign read_data = rd_reg;
    assign row_is_zero = zero_reg;
    assign error = err_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gmrc_pkg::ST_IDLE;
            rows_cfg_reg <= 9'd256;
            cols_cfg_reg <= 9'd256;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == gmrc_pkg::REG_ROWS) rows_cfg_reg <= cfg_data;
                else cols_cfg_reg <= cfg_data;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (state_reg == gmrc_pkg::ST_IDLE && in_valid)
        begin
            cmd_reg <= gmrc_pkg::cmd_t'(command);
            ra_reg <= row_a; rb_reg <= row_b; ca_reg <= col_a; cb_reg <= col_b;
            start_reg <= start_req; scale_reg <= scale; ws_reg <= word_select;
            wd_reg <= 64'(write_data[WORD_BITS-1:0]);
            rd_reg <= 64'd0; zero_reg <= 1'b0; err_reg <= 1'b0;
        end
        if (state_reg == gmrc_pkg::ST_RD_A && idx_reg == 9'd0)
        begin
            // First visit: record errors and arm the zero test.
            err_reg <= bad;
            if (!bad && cmd_reg == gmrc_pkg::CMD_ZERO_TEST) zero_reg <= 1'b1;
        end
        if (state_reg == gmrc_pkg::ST_RD_B) va_reg <= mem_rdata;
        if (state_reg == gmrc_pkg::ST_WAIT)
        begin
            vb_reg <= mem_rdata;
            if (cmd_reg == gmrc_pkg::CMD_READ) rd_reg <= va_reg;
            if (cmd_reg == gmrc_pkg::CMD_ZERO_TEST && (va_reg & last_mask) != 64'd0)
            begin
                zero_reg <= 1'b0;
            end
        end
    end

    // Checks on the sequencer.
    a_single_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("result pending while input is open");
    a_err_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> read_data == 64'd0 && !row_is_zero)
        else $error("error result carries data");
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !mem_we)
        else $error("store written while idle");
endmodule
`default_nettype wire
